>>> hw/rtl/sha1h_pkg.sv
// Shared types, constants and helpers for the SHA-1 / HMAC-SHA1 byte hasher.
// Used by sha1h_core, sha1_hmac_stream_hasher and the bench; no dependencies.
package sha1h_pkg;

    typedef logic [4:0][31:0] sha1h_dig_t;

    typedef struct packed {
        logic       init;
        logic       feed;
        logic [7:0] data;
    } sha1h_ctl_t;

    typedef enum logic [1:0] {
        ACT_KEY = 2'd0,
        ACT_MSG = 2'd1,
        ACT_FIN = 2'd2
    } sha1h_act_t;

    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hefcdab89;
    localparam logic [31:0] H_INIT2 = 32'h98badcfe;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;

    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    localparam logic [7:0] IPAD     = 8'h36;
    localparam logic [7:0] OPAD     = 8'h5c;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // round function plus round constant
    function automatic logic [31:0] sha1h_fk(input logic [6:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        begin
            if (r < 7'd20)
                res = (d ^ (b & (c ^ d))) + K_R0;
            else if (r < 7'd40)
                res = (b ^ c ^ d) + K_R1;
            else if (r < 7'd60)
                res = ((b & c) | (d & (b | c))) + K_R2;
            else
                res = (b ^ c ^ d) + K_R3;
            return res;
        end
    endfunction

    // big-endian byte of a word, sel 0 is the most significant byte
    function automatic logic [7:0] sha1h_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] res;
        begin
            case (sel)
                2'd0:    res = w[31:24];
                2'd1:    res = w[23:16];
                2'd2:    res = w[15:8];
                default: res = w[7:0];
            endcase
            return res;
        end
    endfunction

endpackage

>>> hw/rtl/sha1h_core.sv
// SHA-1 compression core: byte loader, 16-word schedule shift line and one
// round unit reused for 80 rounds. Depends on sha1h_pkg.
module sha1h_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1h_pkg::sha1h_ctl_t ctl,
    output logic                  ready,
    output logic [5:0]            fill,
    output sha1h_pkg::sha1h_dig_t chain
);
    import sha1h_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_RND, C_ADD} cstate_t;

    cstate_t     state_reg, state_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [5:0]  fill_reg, fill_next;
    sha1h_dig_t  chain_reg, chain_next;
    sha1h_dig_t  work_reg, work_next;
    logic [511:0] sched_reg, sched_next;

    logic [31:0] w0, w2, w8, w13, wx, wnew, t_new;

    assign w0   = sched_reg[511:480];
    assign w2   = sched_reg[447:416];
    assign w8   = sched_reg[255:224];
    assign w13  = sched_reg[95:64];
    assign wx   = w13 ^ w8 ^ w2 ^ w0;
    assign wnew = {wx[30:0], wx[31]};

    assign t_new = sha1h_fk(rnd_reg, work_reg[1], work_reg[2], work_reg[3])
                 + {work_reg[0][26:0], work_reg[0][31:27]} + work_reg[4] + w0;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        fill_next  = fill_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        sched_next = sched_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.init)
                begin
                    chain_next = {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};
                    fill_next  = '0;
                end
                else if (ctl.feed)
                begin
                    sched_next = {sched_reg[503:0], ctl.data};
                    fill_next  = fill_reg + 6'd1;
                    // full block: start the rounds
                    if (fill_reg == 6'd63)
                    begin
                        work_next  = chain_reg;
                        rnd_next   = '0;
                        state_next = C_RND;
                    end
                end
            end
            C_RND:
            begin
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[1] = work_reg[0];
                work_next[0] = t_new;
                sched_next   = {sched_reg[479:0], wnew};
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                    state_next = C_ADD;
            end
            C_ADD:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            fill_reg  <= '0;
            chain_reg <= {H_INIT4, H_INIT3, H_INIT2, H_INIT1, H_INIT0};
            work_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fill_reg  <= fill_next;
            chain_reg <= chain_next;
            work_reg  <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
    end

    assign ready = (state_reg == C_IDLE);
    assign fill  = fill_reg;
    assign chain = chain_reg;

    a_feed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.feed |-> state_reg == C_IDLE)
        else $error("byte fed while compressing");
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.feed && !ctl.init && fill_reg == 6'd63 && state_reg == C_IDLE) |=> !ready)
        else $error("full block did not start rounds");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_RND |-> rnd_reg <= LAST_ROUND)
        else $error("round counter out of range");
    a_add_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == C_ADD) |-> $past(rnd_reg) == LAST_ROUND)
        else $error("chain update without 80 rounds");

endmodule

>>> hw/rtl/sha1_hmac_stream_hasher.sv
// Top level: byte-stream SHA-1 / HMAC-SHA1 sequencer with key memory and
// digest output register. Depends on sha1h_pkg and sha1h_core.
//
//   channel   signals                                  direction
//   item      item_valid/item_ready, action, data_byte  in
//   word      word_valid/word_ready, digest_word,       out
//             word_index, last
//   config    cfg_we, cfg_data (hmac_enable)            in
//
// Every 64th byte absorbed starts the shared round unit (80 rounds and then
// the chain add). Finish runs padding, in HMAC mode the 64-byte opad key
// (a read state and a feed state a byte for the key memory read) and the
// inner digest, then five output words.
// item_ready is low throughout that work and while words wait for word_ready.
// Reset is asynchronous; the key memory needs no clearing pass.
module sha1_hmac_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        word_valid,
    input  logic        word_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_data
);
    import sha1h_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ENDK, S_PAD, S_CAPW, S_CAP, S_PKRD, S_PKFD,
        S_CONT, S_FDN, S_IDG, S_OLD, S_OWT
    } state_t;

    typedef enum logic [1:0] {PH_KEY, PH_PLAIN, PH_HMAC} phase_t;

    state_t      state_reg, state_next, ret_reg, ret_next;
    phase_t      phase_reg, phase_next;
    logic        hmac_reg;
    logic        pend_fin_reg, pend_fin_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        outer_reg, outer_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] klen_reg, klen_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_len_reg, pad_len_next;
    logic [7:0]  padv_reg, padv_next;
    logic [63:0] kvld_reg, kvld_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    sha1h_dig_t  inner_reg, inner_next;

    logic [7:0]  key_mem [64];
    logic [7:0]  krd_reg;
    logic        kvrd_reg;
    logic        kwe;
    logic [5:0]  kwaddr;
    logic [7:0]  kwdata;

    sha1h_ctl_t  ctl;
    logic        core_ready;
    logic [5:0]  fill;
    sha1h_dig_t  chain;

    logic        acc;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [7:0]  cap_byte;
    logic [7:0]  idg_byte;

    sha1h_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .ready (core_ready),
        .fill  (fill),
        .chain (chain)
    );

    assign item_ready = (state_reg == S_IDLE) && core_ready;
    assign acc        = item_valid && item_ready;
    assign len_bits   = {29'd0, total_reg, 3'd0};
    assign len_byte   = 8'(len_bits >> {3'd7 - cnt_reg[2:0], 3'd0});
    assign cap_byte   = sha1h_byte(chain[cnt_reg[4:2]], cnt_reg[1:0]);
    assign idg_byte   = sha1h_byte(inner_reg[cnt_reg[4:2]], cnt_reg[1:0]);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        pend_fin_next  = pend_fin_reg;
        pend_byte_next = pend_byte_reg;
        outer_next     = outer_reg;
        total_next     = total_reg;
        klen_next      = klen_reg;
        cnt_next       = cnt_reg;
        pad_first_next = pad_first_reg;
        pad_len_next   = pad_len_reg;
        padv_next      = padv_reg;
        kvld_next      = kvld_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        ovalid_next    = ovalid_reg;
        inner_next     = inner_reg;
        ctl            = '0;
        kwe            = 1'b0;
        kwaddr         = klen_reg[5:0];
        kwdata         = data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (action)
                        ACT_KEY:
                        begin
                            if (phase_reg == PH_KEY && hmac_reg)
                            begin
                                if (klen_reg < 32'd64)
                                begin
                                    kwe = 1'b1;
                                    kvld_next[klen_reg[5:0]] = 1'b1;
                                end
                                if (klen_reg != 32'hffffffff)
                                    klen_next = klen_reg + 32'd1;
                                ctl.feed   = 1'b1;
                                ctl.data   = data_byte;
                                total_next = total_reg + 32'd1;
                            end
                        end
                        ACT_MSG:
                        begin
                            if (phase_reg == PH_KEY)
                            begin
                                pend_fin_next  = 1'b0;
                                pend_byte_next = data_byte;
                                state_next     = S_ENDK;
                            end
                            else
                            begin
                                ctl.feed   = 1'b1;
                                ctl.data   = data_byte;
                                total_next = total_reg + 32'd1;
                            end
                        end
                        ACT_FIN:
                        begin
                            pend_fin_next = 1'b1;
                            if (phase_reg == PH_KEY)
                                state_next = S_ENDK;
                            else
                                state_next = S_CONT;
                        end
                        default: ;
                    endcase
                end
            end
            S_ENDK:
            begin
                if (core_ready)
                begin
                    if (!hmac_reg)
                    begin
                        ctl.init   = 1'b1;
                        total_next = '0;
                        phase_next = PH_PLAIN;
                        state_next = S_CONT;
                    end
                    else if (klen_reg > 32'd64)
                    begin
                        // long key: hash it, the digest becomes the key
                        kvld_next      = '0;
                        pad_first_next = 1'b1;
                        pad_len_next   = 1'b0;
                        ret_next       = S_CAPW;
                        state_next     = S_PAD;
                    end
                    else
                    begin
                        ctl.init   = 1'b1;
                        total_next = '0;
                        cnt_next   = '0;
                        padv_next  = IPAD;
                        phase_next = PH_HMAC;
                        ret_next   = S_CONT;
                        state_next = S_PKRD;
                    end
                end
            end
            S_PAD:
            begin
                if (core_ready)
                begin
                    if (pad_first_reg)
                    begin
                        ctl.feed       = 1'b1;
                        ctl.data       = PAD_MARK;
                        pad_first_next = 1'b0;
                    end
                    else if (!pad_len_reg)
                    begin
                        if (fill == LEN_OFFSET)
                        begin
                            pad_len_next = 1'b1;
                            cnt_next     = '0;
                        end
                        else
                        begin
                            ctl.feed = 1'b1;
                            ctl.data = 8'h00;
                        end
                    end
                    else
                    begin
                        ctl.feed = 1'b1;
                        ctl.data = len_byte;
                        cnt_next = cnt_reg + 7'd1;
                        if (cnt_reg[2:0] == 3'd7)
                            state_next = ret_reg;
                    end
                end
            end
            S_CAPW:
            begin
                if (core_ready)
                begin
                    cnt_next   = '0;
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                kwe                     = 1'b1;
                kwaddr                  = cnt_reg[5:0];
                kwdata                  = cap_byte;
                kvld_next[cnt_reg[5:0]] = 1'b1;
                cnt_next                = cnt_reg + 7'd1;
                if (cnt_reg == 7'd19)
                begin
                    ctl.init   = 1'b1;
                    total_next = '0;
                    cnt_next   = '0;
                    padv_next  = IPAD;
                    phase_next = PH_HMAC;
                    ret_next   = S_CONT;
                    state_next = S_PKRD;
                end
            end
            S_PKRD:
            begin
                state_next = S_PKFD;
            end
            S_PKFD:
            begin
                if (core_ready)
                begin
                    ctl.feed   = 1'b1;
                    ctl.data   = (kvrd_reg ? krd_reg : 8'h00) ^ padv_reg;
                    total_next = total_reg + 32'd1;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                    begin
                        cnt_next   = '0;
                        state_next = ret_reg;
                    end
                    else
                        state_next = S_PKRD;
                end
            end
            S_CONT:
            begin
                if (pend_fin_reg)
                begin
                    pad_first_next = 1'b1;
                    pad_len_next   = 1'b0;
                    ret_next       = S_FDN;
                    state_next     = S_PAD;
                end
                else if (core_ready)
                begin
                    ctl.feed   = 1'b1;
                    ctl.data   = pend_byte_reg;
                    total_next = total_reg + 32'd1;
                    state_next = S_IDLE;
                end
            end
            S_FDN:
            begin
                if (core_ready)
                begin
                    cnt_next = '0;
                    if (phase_reg == PH_HMAC && !outer_reg)
                    begin
                        inner_next = chain;
                        ctl.init   = 1'b1;
                        total_next = '0;
                        outer_next = 1'b1;
                        padv_next  = OPAD;
                        ret_next   = S_IDG;
                        state_next = S_PKRD;
                    end
                    else
                        state_next = S_OLD;
                end
            end
            S_IDG:
            begin
                if (core_ready)
                begin
                    ctl.feed   = 1'b1;
                    ctl.data   = idg_byte;
                    total_next = total_reg + 32'd1;
                    cnt_next   = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd19)
                    begin
                        pad_first_next = 1'b1;
                        pad_len_next   = 1'b0;
                        ret_next       = S_FDN;
                        state_next     = S_PAD;
                    end
                end
            end
            S_OLD:
            begin
                word_next   = chain[cnt_reg[2:0]];
                idx_next    = cnt_reg[2:0];
                ovalid_next = 1'b1;
                state_next  = S_OWT;
            end
            S_OWT:
            begin
                if (word_ready)
                begin
                    ovalid_next = 1'b0;
                    cnt_next    = cnt_reg + 7'd1;
                    state_next  = S_OLD;
                    if (cnt_reg[2:0] == 3'd4)
                    begin
                        // back to the initial state, drop the key
                        ctl.init   = 1'b1;
                        total_next = '0;
                        klen_next  = '0;
                        kvld_next  = '0;
                        outer_next = 1'b0;
                        phase_next = PH_KEY;
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            phase_reg     <= PH_KEY;
            hmac_reg      <= 1'b0;
            pend_fin_reg  <= 1'b0;
            outer_reg     <= 1'b0;
            total_reg     <= '0;
            klen_reg      <= '0;
            cnt_reg       <= '0;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            kvld_reg      <= '0;
            ovalid_reg    <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            if (cfg_we)
                hmac_reg  <= cfg_data;
            pend_fin_reg  <= pend_fin_next;
            outer_reg     <= outer_next;
            total_reg     <= total_next;
            klen_reg      <= klen_next;
            cnt_reg       <= cnt_next;
            pad_first_reg <= pad_first_next;
            pad_len_reg   <= pad_len_next;
            kvld_reg      <= kvld_next;
            ovalid_reg    <= ovalid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        padv_reg      <= padv_next;
        word_reg      <= word_next;
        inner_reg     <= inner_next;
    end

    always_ff @(posedge clk)
    begin
        if (kwe)
            key_mem[kwaddr] <= kwdata;
        krd_reg  <= key_mem[cnt_reg[5:0]];
        kvrd_reg <= kvld_reg[cnt_reg[5:0]];
    end

    assign word_valid  = ovalid_reg;
    assign digest_word = word_reg;
    assign word_index  = idx_reg;
    assign last        = (idx_reg == 3'd4);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> !item_ready)
        else $error("input taken while digest word pending");
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> state_reg == S_OWT)
        else $error("digest word valid outside output state");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> idx_reg <= 3'd4)
        else $error("digest word index out of range");
    a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && word_ready && last) |=> (phase_reg == PH_KEY && total_reg == '0))
        else $error("state not restored after last word");

endmodule

>>> bench/sha1_hmac_digest_checker.sv
// Digest checker for sha1_hmac_stream_hasher: watches the item, word and config ports,
// predicts the SHA-1 / HMAC-SHA1 digest words and compares them. Depends on sha1h_pkg.
module sha1_hmac_digest_checker
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        word_valid,
    input  logic        word_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last,
    input  logic        cfg_we,
    input  logic        cfg_data,
    output int          errors,
    output int          pending,
    output int          digests
);

    typedef enum logic [1:0] {ST_KEY, ST_PLAIN, ST_HMAC} hash_state_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    digest_word_t digest_q[$];

    logic        hmac_on;
    logic [31:0] chain[5];
    logic [31:0] wv[5];
    logic [31:0] sched[16];
    logic [5:0]  fill;
    logic [31:0] total_len;
    logic [7:0]  key_mem[64];
    logic [31:0] key_len;
    logic [31:0] inner[5];
    hash_state_t hstate;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] f;
        for (int i = 0; i < 5; i++)
            wv[i] = chain[i];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
                sched[r & 15] = rol(sched[(r + 13) & 15] ^ sched[(r + 8) & 15]
                                    ^ sched[(r + 2) & 15] ^ sched[r & 15], 1);
            if (r < 20)
                f = (wv[3] ^ (wv[1] & (wv[2] ^ wv[3]))) + K_R0;
            else if (r < 40)
                f = (wv[1] ^ wv[2] ^ wv[3]) + K_R1;
            else if (r < 60)
                f = ((wv[1] & wv[2]) | (wv[3] & (wv[1] | wv[2]))) + K_R2;
            else
                f = (wv[1] ^ wv[2] ^ wv[3]) + K_R3;
            f = f + rol(wv[0], 5) + wv[4] + sched[r & 15];
            wv[4] = wv[3];
            wv[3] = wv[2];
            wv[2] = rol(wv[1], 30);
            wv[1] = wv[0];
            wv[0] = f;
        end
        for (int i = 0; i < 5; i++)
            chain[i] = chain[i] + wv[i];
    endfunction

    function automatic void absorb(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * fill[1:0];
        sched[fill[5:2]][sh +: 8] = b;
        if (fill == 6'd63)
            compress_block();
        fill = fill + 6'd1;
    endfunction

    function automatic void absorb_counted(input logic [7:0] b);
        total_len = total_len + 32'd1;
        absorb(b);
    endfunction

    function automatic void restart();
        chain[0] = H_INIT0;
        chain[1] = H_INIT1;
        chain[2] = H_INIT2;
        chain[3] = H_INIT3;
        chain[4] = H_INIT4;
        fill = '0;
        total_len = '0;
    endfunction

    // append 0x80, zeros and the 64-bit length in bits, eight times the byte count
    function automatic void pad_out();
        logic [31:0] n;
        n = total_len;
        absorb(PAD_MARK);
        while (fill != LEN_OFFSET)
            absorb(8'h00);
        repeat (3) absorb(8'h00);
        absorb(8'(n >> 29));
        absorb(8'(n >> 21));
        absorb(8'(n >> 13));
        absorb(8'(n >> 5));
        absorb(8'(n << 3));
    endfunction

    function automatic void absorb_key(input logic [7:0] pad);
        for (int i = 0; i < 64; i++)
            absorb_counted(key_mem[i] ^ pad);
    endfunction

    function automatic void clear_all();
        restart();
        for (int i = 0; i < 5; i++)
        begin
            wv[i] = '0;
            inner[i] = '0;
        end
        for (int i = 0; i < 16; i++)
            sched[i] = '0;
        for (int i = 0; i < 64; i++)
            key_mem[i] = '0;
        key_len = '0;
        hstate = ST_KEY;
    endfunction

    function automatic void close_key();
        if (!hmac_on)
        begin
            restart();
            hstate = ST_PLAIN;
            return;
        end
        // long key: replace it with its own digest
        if (key_len > 32'd64)
        begin
            pad_out();
            for (int i = 0; i < 64; i++)
                key_mem[i] = '0;
            for (int i = 0; i < 20; i++)
                key_mem[i] = chain[i >> 2][24 - 8 * (i & 3) +: 8];
        end
        restart();
        absorb_key(IPAD);
        hstate = ST_HMAC;
    endfunction

    function automatic void hash_step(input logic [1:0] act, input logic [7:0] b);
        digest_word_t e;
        if (act == ACT_KEY)
        begin
            if (hstate == ST_KEY && hmac_on)
            begin
                if (key_len < 32'd64)
                    key_mem[key_len[5:0]] = b;
                if (key_len != 32'hffffffff)
                    key_len = key_len + 32'd1;
                absorb_counted(b);
            end
        end
        else if (act == ACT_MSG)
        begin
            if (hstate == ST_KEY)
                close_key();
            absorb_counted(b);
        end
        else if (act == ACT_FIN)
        begin
            if (hstate == ST_KEY)
                close_key();
            pad_out();
            if (hstate == ST_HMAC)
            begin
                for (int i = 0; i < 5; i++)
                    inner[i] = chain[i];
                restart();
                absorb_key(OPAD);
                for (int i = 0; i < 20; i++)
                    absorb_counted(inner[i >> 2][24 - 8 * (i & 3) +: 8]);
                pad_out();
            end
            for (int i = 0; i < 5; i++)
            begin
                e.word = chain[i];
                e.index = 3'(i);
                e.last = (i == 4);
                digest_q.push_back(e);
            end
            clear_all();
        end
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors = errors + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t e;
        if (!rst_n)
        begin
            hmac_on = 1'b0;
            clear_all();
            digest_q.delete();
            errors = 0;
            digests = 0;
        end
        else
        begin
            if (cfg_we)
                hmac_on = cfg_data;
            if (item_valid && item_ready)
                hash_step(action, data_byte);
            if (word_valid && word_ready)
            begin
                if (digest_q.size() == 0)
                    report($sformatf("unexpected word %h index %0d", digest_word, word_index));
                else
                begin
                    e = digest_q.pop_front();
                    if (digest_word !== e.word)
                        report($sformatf("digest_word %h, want %h (index %0d)",
                                         digest_word, e.word, e.index));
                    if (word_index !== e.index)
                        report($sformatf("word_index %0d, want %0d", word_index, e.index));
                    if (last !== e.last)
                        report($sformatf("last %b, want %b at index %0d", last, e.last, e.index));
                    if (e.last)
                        digests = digests + 1;
                end
            end
        end
        pending = digest_q.size();
    end

endmodule

>>> bench/tb_sha1_hmac_stream_hasher.sv
// Testbench top for sha1_hmac_stream_hasher: drives key, message and finish words
// plus config writes; sha1_hmac_digest_checker does the checking. Depends on sha1h_pkg.
module tb_sha1_hmac_stream_hasher;
    import sha1h_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_WORDS = 330;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 200;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        word_valid;
    logic        word_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    logic        cfg_we;
    logic        cfg_data;

    int errors;
    int pending;
    int digests;
    int sent;
    int messages;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    sha1_hmac_stream_hasher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .data_byte   (data_byte),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    sha1_hmac_digest_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .data_byte   (data_byte),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .digests     (digests)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        word_ready <= ($urandom_range(99) >= recv_stall_pct);

    // hold the word until accepted; leave valid high for a following word
    task automatic send(input logic [1:0] act, input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        data_byte <= b;
        forever
        begin
            @(negedge clk);
            if (item_ready)
                break;
        end
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic on);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= on;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // key bytes, message bytes, finish; noise sprinkled in when asked
    task automatic hash_message(input int key_n, input int msg_n, input logic fill_ff,
                                input bit noisy);
        logic [7:0] b;
        for (int i = 0; i < key_n; i++)
        begin
            b = fill_ff ? 8'hff : 8'($urandom);
            send(ACT_KEY, b);
            if (noisy && $urandom_range(9) == 0)
                send(ACT_NONE, 8'($urandom));
        end
        for (int i = 0; i < msg_n; i++)
        begin
            b = fill_ff ? 8'h00 : 8'($urandom);
            send(ACT_MSG, b);
            if (noisy && $urandom_range(9) == 0)
                send($urandom_range(1) ? ACT_KEY : ACT_NONE, 8'($urandom));
        end
        send(ACT_FIN, 8'($urandom));
        messages++;
    endtask

    initial
    begin
        int kn;
        int mn;
        int r;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        action = ACT_KEY;
        data_byte = '0;
        word_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        cycles = 0;
        sent = 0;
        messages = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain: empty message, key bytes ignored, no-op action, "abc"
        hash_message(0, 0, 1'b0, 1'b0);
        send(ACT_KEY, 8'hff);
        send(ACT_NONE, 8'h00);
        send(ACT_MSG, 8'h61);
        send(ACT_MSG, 8'h62);
        send(ACT_MSG, 8'h63);
        send(ACT_FIN, 8'h00);
        messages++;
        write_mode(1'b1);
        // hmac: empty key and message, a full 64-byte key, a key just over 64
        hash_message(0, 0, 1'b0, 1'b0);
        hash_message(64, 1, 1'b1, 1'b0);
        hash_message(65, 3, 1'b0, 1'b0);
        // key byte after message start is dropped
        send(ACT_KEY, 8'h01);
        send(ACT_MSG, 8'hff);
        send(ACT_KEY, 8'h02);
        send(ACT_FIN, 8'h00);
        messages++;
        write_mode(1'b0);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (sent * 4 / RANDOM_WORDS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if ($urandom_range(3) == 0)
                write_mode(1'($urandom_range(1)));
            r = $urandom_range(99);
            kn = (r < 55) ? $urandom_range(0, 8) :
                 (r < 85) ? $urandom_range(9, 64) :
                 (r < 93) ? $urandom_range(64, 65) : $urandom_range(66, 130);
            r = $urandom_range(99);
            mn = (r < 60) ? $urandom_range(0, 12) :
                 (r < 90) ? $urandom_range(13, 70) : $urandom_range(71, 140);
            hash_message(kn, mn, 1'b0, $urandom_range(3) == 0);
        end

        drain();
        $display("Covered %0d messages over plain and HMAC modes, %0d digests compared.",
                 messages, digests);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sha1h_pkg.sv
hw/rtl/sha1h_core.sv
hw/rtl/sha1_hmac_stream_hasher.sv
bench/sha1_hmac_digest_checker.sv
bench/tb_sha1_hmac_stream_hasher.sv
